/* hdl/shq_pkg.sv */
// Shared types and constants for the shifting queue with indexed removal.
// Used by shq_core and the top level; depends on nothing.
package shq_pkg;

   localparam int DATA_W      = 32;
   localparam int POS_W       = 4;
   localparam int COUNT_W     = 5;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [1:0] {
      OP_INSERT      = 2'd0,
      OP_REMOVE_HEAD = 2'd1,
      OP_REMOVE_AT   = 2'd2,
      OP_PEEK        = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_BAD_POS = 2'd3
   } status_type;

   // One request item as held in the input register
   typedef struct packed {
      op_type             operation;
      logic [DATA_W-1:0]  value;
      logic [POS_W-1:0]   position;
   } req_type;

   // One result item as produced by the core
   typedef struct packed {
      logic [DATA_W-1:0]  data;
      status_type         status;
      logic [COUNT_W-1:0] count;
      logic               is_full;
      logic               is_empty;
   } rsp_type;

endpackage

/* hdl/shq_core.sv */
// Entry row, occupancy counter and per-operation update logic of the queue.
// Depends on shq_pkg; instantiated by shifting_queue_with_indexed_removal_top.
module shq_core #(
   parameter int DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   input  shq_pkg::req_type req,
   output shq_pkg::rsp_type rsp
);
   import shq_pkg::*;

   localparam int OW = $clog2(DEPTH + 1);
   localparam int CW = (OW > POS_W) ? OW : POS_W;

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [DATA_W-1:0] entry_in [DEPTH];
   logic [OW-1:0]     occ_ff;
   logic [OW-1:0]     occ_in;

   logic [CW-1:0]     occ_w;
   logic [CW-1:0]     pos_w;
   logic [CW-1:0]     tail_w;
   logic [CW-1:0]     rm_idx;
   logic              do_insert;
   logic              do_remove;
   logic [DATA_W-1:0] rm_word;
   logic [DATA_W-1:0] tail_word;
   logic [DATA_W-1:0] data;
   status_type        status;

   assign occ_w  = CW'(occ_ff);
   assign pos_w  = CW'(req.position);
   assign tail_w = occ_w - CW'(1);

   // Decode the operation against the current occupancy
   always_comb begin
      do_insert = 1'b0;
      do_remove = 1'b0;
      rm_idx    = '0;
      unique case (req.operation)
         OP_INSERT:      do_insert = (occ_w < CW'(DEPTH));
         OP_REMOVE_HEAD: do_remove = (occ_w != '0);
         OP_REMOVE_AT: begin
            do_remove = (pos_w < occ_w);
            rm_idx    = pos_w;
         end
         default: ;
      endcase
   end

   // AND-OR select of the removed word and the tail word, one compare per entry
   always_comb begin
      rm_word   = '0;
      tail_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rm_word   = rm_word   | (entry_ff[i] & {DATA_W{CW'(i) == rm_idx}});
         tail_word = tail_word | (entry_ff[i] & {DATA_W{CW'(i) == tail_w}});
      end
   end

   // Next value of each entry: load at the first free slot, or take the upper neighbor
   for (genvar g = 0; g < DEPTH; g++) begin : g_entry
      if (g < DEPTH - 1) begin : g_shift
         always_comb begin
            entry_in[g] = entry_ff[g];
            if (do_insert && CW'(g) == occ_w) begin
               entry_in[g] = req.value;
            end else if (do_remove && CW'(g) >= rm_idx) begin
               entry_in[g] = entry_ff[g+1];
            end
         end
      end else begin : g_top
         always_comb begin
            entry_in[g] = entry_ff[g];
            if (do_insert && CW'(g) == occ_w) begin
               entry_in[g] = req.value;
            end
         end
      end
   end

   // Occupancy update
   always_comb begin
      occ_in = occ_ff;
      if (do_insert) begin
         occ_in = occ_ff + OW'(1);
      end else if (do_remove) begin
         occ_in = occ_ff - OW'(1);
      end
   end

   // Result word and status
   always_comb begin
      data   = '0;
      status = ST_OK;
      unique case (req.operation)
         OP_INSERT: begin
            if (!do_insert) status = ST_FULL;
         end
         OP_REMOVE_HEAD: begin
            if (do_remove) begin
               data = rm_word;
            end else begin
               data   = '1;
               status = ST_EMPTY;
            end
         end
         OP_REMOVE_AT: begin
            if (do_remove) data = rm_word;
            else           status = ST_BAD_POS;
         end
         OP_PEEK: begin
            if (occ_w != '0) data = tail_word;
            else             status = ST_EMPTY;
         end
         default: ;
      endcase
   end

   assign rsp.data     = data;
   assign rsp.status   = status;
   assign rsp.count    = COUNT_W'(occ_in);
   assign rsp.is_full  = (occ_in == OW'(DEPTH));
   assign rsp.is_empty = (occ_in == '0);

   // Entry row holds payload only, no reset
   always_ff @(posedge clock) begin
      if (go) begin
         for (int i = 0; i < DEPTH; i++) begin
            entry_ff[i] <= entry_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (go) begin
         occ_ff <= occ_in;
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(DEPTH))
      else $error("occupancy above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      go && do_insert |=> occ_ff == $past(occ_ff) + OW'(1))
      else $error("insert did not grow occupancy");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      go && rsp.status == ST_FULL |-> rsp.is_full)
      else $error("full status on a queue that is not full");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      go && do_remove |=> occ_ff == $past(occ_ff) - OW'(1))
      else $error("remove did not shrink occupancy");

endmodule

/* hdl/shifting_queue_with_indexed_removal_top.sv */
// Top level of the shifting queue: input register, queue core, result register.
// Depends on shq_pkg and shq_core.
// An accepted request item passes the input register, then the result register.
// Throughput: 1 item per cycle while rsp_ is not stalled; the entry row updates once per item.
// Backpressure on rsp_ stalls the core and, one item later, req_tready.
// Reset: synchronous, active high; clears occupancy and valids, not the entries.
module shifting_queue_with_indexed_removal_top #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] value, [35:32] position, [39:36] zero
   input  logic [shq_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] operation
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] data, [36:32] count, [37] is_full, [38] is_empty, [39] zero
   output logic [shq_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // [1:0] status
   output logic [1:0]                         rsp_tuser
);
   import shq_pkg::*;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_req_ff;
   req_type req_item;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type core_rsp;
   logic    advance;
   logic    take;

   // Unpack the request item
   assign req_item.operation = op_type'(req_tuser);
   assign req_item.value     = req_tdata[DATA_W-1:0];
   assign req_item.position  = req_tdata[DATA_W+POS_W-1:DATA_W];

   // Handshake: the core advances when the result register is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   assign in_valid_in  = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   shq_core #(
      .DEPTH (DEPTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .go    (advance),
      .req   (in_req_ff),
      .rsp   (core_rsp)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_req_ff <= req_item;
      end
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   // Pack the result item
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {1'b0, rsp_ff.is_empty, rsp_ff.is_full, rsp_ff.count, rsp_ff.data};

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input item lost while stalled");

   a_rsp_after_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("no result after core advance");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !advance)
      else $error("result overwritten while stalled");

endmodule
